// ----- design/per_flow_duplicate_filter_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the per-flow duplicate filter
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef PER_FLOW_DUPLICATE_FILTER_MACROS_SVH
`define PER_FLOW_DUPLICATE_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge out of reset.
`define PFDF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("per_flow_duplicate_filter: assertion failed");
// A condition that, when true, requires a consequence in the next cycle.
`define PFDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("per_flow_duplicate_filter: assertion failed");
`else
`define PFDF_ASSERT(lbl, prop)
`define PFDF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/pfdf_pkg.sv -----
// ---------------------------------------------------------------------------
// Per-flow duplicate filter package
// Table sizing, verdict codes and the request and result structures.
// ---------------------------------------------------------------------------
`default_nettype none

package pfdf_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int KEY_WIDTH     = 32;
  localparam int NUM_WIDTH     = 32;
  localparam int KEY_IN_WIDTH  = 32;

  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int ENTRY_W = KEY_WIDTH + NUM_WIDTH;

  typedef enum logic [2:0] {
    VERDICT_NEW       = 3'd0,
    VERDICT_ROLLOVER  = 3'd1,
    VERDICT_INCREASE  = 3'd2,
    VERDICT_OBSOLETE  = 3'd3,
    VERDICT_MALFORMED = 3'd4,
    VERDICT_FULL      = 3'd5
  } verdict_e;

  typedef struct packed {
    logic [KEY_IN_WIDTH-1:0]     connection_key;
    logic signed [NUM_WIDTH-1:0] message_number;
    logic                        well_formed;
  } req_t;

  typedef struct packed {
    logic     is_unique;
    verdict_e verdict;
  } res_t;

  // Only the low KEY_WIDTH bits of the incoming key take part in a match.
  function automatic logic [KEY_WIDTH-1:0] key_of(logic [KEY_IN_WIDTH-1:0] k);
    logic [KEY_WIDTH+KEY_IN_WIDTH-1:0] ext;
    ext = {{KEY_WIDTH{1'b0}}, k};
    return ext[KEY_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/pfdf_ram.sv -----
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module pfdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/pfdf_engine.sv -----
// ---------------------------------------------------------------------------
// Per-flow duplicate filter lookup engine
// Scans the flow table one entry a cycle, judges the message and writes back.
// ---------------------------------------------------------------------------
`default_nettype none

module pfdf_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output      logic          req_ready_o,
  input  wire pfdf_pkg::req_t req_i,
  output      logic          res_valid_o,
  input  wire logic          res_ready_i,
  output      pfdf_pkg::res_t res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                           state_q, state_d;
  logic [pfdf_pkg::KEY_WIDTH-1:0]       key_q, key_d;
  logic signed [pfdf_pkg::NUM_WIDTH-1:0] num_q, num_d;
  logic [pfdf_pkg::CNT_W-1:0]           rd_cnt_q, rd_cnt_d;
  logic [pfdf_pkg::CNT_W-1:0]           used_q, used_d;
  logic                                 cmp_vld_q, cmp_vld_d;
  logic [pfdf_pkg::IDX_W-1:0]           cmp_idx_q, cmp_idx_d;
  pfdf_pkg::res_t                       res_q, res_d;

  logic                                 rd_en;
  logic [pfdf_pkg::ENTRY_W-1:0]         rdata;
  logic [pfdf_pkg::KEY_WIDTH-1:0]       stored_key;
  logic signed [pfdf_pkg::NUM_WIDTH-1:0] stored_num;
  logic                                 hit, miss, has_room;
  logic                                 hit_unique;
  pfdf_pkg::verdict_e                   hit_verdict;
  logic                                 we;
  logic [pfdf_pkg::IDX_W-1:0]           waddr;

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // Entries fill in order and are never freed, so entry i is in use
  // exactly when i is below the fill count.
  assign rd_en      = (state_q == S_SCAN) && (rd_cnt_q < used_q);
  assign stored_key = rdata[pfdf_pkg::KEY_WIDTH-1:0];
  assign stored_num = rdata[pfdf_pkg::KEY_WIDTH +: pfdf_pkg::NUM_WIDTH];
  assign hit        = (state_q == S_SCAN) && cmp_vld_q && (stored_key == key_q);
  assign miss       = (state_q == S_SCAN) && !cmp_vld_q && (rd_cnt_q == used_q);
  assign has_room   = used_q < pfdf_pkg::CNT_W'(pfdf_pkg::TABLE_ENTRIES);

  always_comb begin
    if ((num_q < 0) && (stored_num > 0)) begin
      hit_unique  = 1'b1;
      hit_verdict = pfdf_pkg::VERDICT_ROLLOVER;
    end else if (num_q > stored_num) begin
      hit_unique  = 1'b1;
      hit_verdict = pfdf_pkg::VERDICT_INCREASE;
    end else begin
      hit_unique  = 1'b0;
      hit_verdict = pfdf_pkg::VERDICT_OBSOLETE;
    end
  end

  assign we    = (hit && hit_unique) || (miss && has_room);
  assign waddr = hit ? cmp_idx_q : used_q[pfdf_pkg::IDX_W-1:0];

  pfdf_ram #(
    .WIDTH (pfdf_pkg::ENTRY_W),
    .DEPTH (pfdf_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({num_q, key_q}),
    .re_i    (rd_en),
    .raddr_i (rd_cnt_q[pfdf_pkg::IDX_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    num_d     = num_q;
    rd_cnt_d  = rd_cnt_q;
    used_d    = used_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    res_d     = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          key_d    = pfdf_pkg::key_of(req_i.connection_key);
          num_d    = req_i.message_number;
          rd_cnt_d = '0;
          if (!req_i.well_formed) begin
            res_d   = '{is_unique: 1'b1, verdict: pfdf_pkg::VERDICT_MALFORMED};
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmp_vld_d = rd_en;
        cmp_idx_d = rd_cnt_q[pfdf_pkg::IDX_W-1:0];
        if (rd_en) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        if (hit) begin
          cmp_vld_d = 1'b0;
          res_d     = '{is_unique: hit_unique, verdict: hit_verdict};
          state_d   = S_DONE;
        end else if (miss) begin
          if (has_room) begin
            used_d = used_q + 1'b1;
            res_d  = '{is_unique: 1'b1, verdict: pfdf_pkg::VERDICT_NEW};
          end else begin
            res_d  = '{is_unique: 1'b1, verdict: pfdf_pkg::VERDICT_FULL};
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      rd_cnt_q  <= rd_cnt_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    num_q     <= num_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
  end

endmodule

`default_nettype wire

// ----- design/per_flow_duplicate_filter.sv -----
// ---------------------------------------------------------------------------
// Per-flow duplicate filter
// Passes or drops messages by comparing each sequence number with the last
// one accepted on the same connection.
// ---------------------------------------------------------------------------
// Each input transfer carries a connection key and a signed 32-bit message
// number in tdata and the well-formed flag in tuser; each produces exactly one
// output transfer with the pass flag in tdata and a 3-bit verdict in tuser.
// A malformed message goes from the engine's result register straight to the
// output register, with no table lookup. Any other message is looked up in the
// flow table, which sits in one RAM with a registered read port: the engine
// reads one entry per cycle in fill order until the key matches or every learnt
// entry has been checked. A key that is not in the table is checked against
// every connection learnt so far (at most 64). The engine takes the next item
// in the cycle after its result has moved into the output register. The table
// needs no clearing pass after reset, as a fill count marks which entries are
// live. One item is processed at a time; a finished result waits in the output
// register, so the next item is accepted while the previous result is still
// held.
`default_nettype none

`include "per_flow_duplicate_filter_macros.svh"

module per_flow_duplicate_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [31:0] connection_key, [63:32] message_number
  input  wire logic        s_axis_tuser,   // [0] well_formed
  // Output stream.
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,   // [0] is_unique, [7:1] zero
  output      logic [2:0]  m_axis_tuser    // [2:0] verdict
);

  pfdf_pkg::req_t req;
  pfdf_pkg::res_t eng_res;
  logic           eng_res_valid;
  logic           eng_res_ready;

  logic           out_valid_q, out_valid_d;
  pfdf_pkg::res_t out_res_q, out_res_d;

  // Unpack the input transfer into the request structure.
  assign req.connection_key = s_axis_tdata[31:0];
  assign req.message_number = s_axis_tdata[63:32];
  assign req.well_formed    = s_axis_tuser;

  pfdf_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (eng_res_valid),
    .res_ready_i (eng_res_ready),
    .res_o       (eng_res)
  );

  // The output register takes a new result whenever it is empty or its
  // current contents are being transferred in this cycle.
  assign eng_res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (eng_res_ready) begin
      out_valid_d = eng_res_valid;
      if (eng_res_valid) begin
        out_res_d = eng_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_res_q.is_unique};
  assign m_axis_tuser  = out_res_q.verdict;

  // Only the obsolete verdict drops a message.
  `PFDF_ASSERT(a_unique_matches_verdict, !m_axis_tvalid || (m_axis_tdata[0] == (m_axis_tuser != pfdf_pkg::VERDICT_OBSOLETE)))
  // A result the output register cannot take stays put inside the engine.
  `PFDF_ASSERT_NEXT(a_engine_holds_result, eng_res_valid && !eng_res_ready, eng_res_valid && $stable(eng_res))
  // The engine never takes a new message while it still holds a result.
  `PFDF_ASSERT(a_no_accept_with_result, !(s_axis_tready && eng_res_valid))

endmodule

`default_nettype wire
